>>> sv/nler_pkg.sv
// Package for the node liveness / election / retry block.
// Holds table sizes, opcodes, event and role codes and the control structs.
// No dependencies.
`default_nettype none
package nler_pkg;
   localparam int NODE_SLOTS = 16;
   localparam int ID_W       = 4;

   localparam logic [1:0] OP_STATUS = 2'd0;
   localparam logic [1:0] OP_FAULT  = 2'd1;
   localparam logic [1:0] OP_ACK    = 2'd2;
   localparam logic [1:0] OP_PASS   = 2'd3;

   localparam logic [1:0] ST_ONLINE  = 2'd0;
   localparam logic [1:0] ST_OFFLINE = 2'd1;
   localparam logic [1:0] ST_FAULT   = 2'd2;

   localparam logic [1:0] ROLE_IDLE     = 2'd0;
   localparam logic [1:0] ROLE_LEADER   = 2'd1;
   localparam logic [1:0] ROLE_FOLLOWER = 2'd2;

   localparam logic [2:0] EV_SEND    = 3'd0;
   localparam logic [2:0] EV_RETRY   = 3'd1;
   localparam logic [2:0] EV_TIMEOUT = 3'd2;
   localparam logic [2:0] EV_LEADER  = 3'd3;
   localparam logic [2:0] EV_ACK     = 3'd4;
   localparam logic [2:0] EV_DONE    = 3'd5;

   localparam logic [1:0] CSR_SILENCE = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_RETRY   = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic do_report;
      logic do_ack;
      logic scan1_step;
      logic lead_step;
      logic scan2_step;
      logic done_step;
      logic idx_inc;
      logic idx_clr;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       out_free;
      logic       ack_hit;
      logic       lead_diff;
      logic       scan2_emit;
      logic       idx_last;
   } stat_type;
endpackage
`default_nettype wire

>>> sv/nler_ctrl.sv
// Controller state machine for the node liveness block.
// Sequences reports, acks and the two table scans of a service pass; uses nler_pkg.
`default_nettype none
module nler_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_accept,
   output logic                   idle,
   input  wire nler_pkg::stat_type st,
   output nler_pkg::cmd_type      cmd
);
   import nler_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_REP   = 3'd1;
   localparam logic [2:0] S_ACK   = 3'd2;
   localparam logic [2:0] S_SCAN1 = 3'd3;
   localparam logic [2:0] S_LEAD  = 3'd4;
   localparam logic [2:0] S_SCAN2 = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign idle = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd.load_item = 1'b1;
               case (st.op)
                  OP_STATUS, OP_FAULT: state_in = S_REP;
                  OP_ACK:              state_in = S_ACK;
                  default:             state_in = S_SCAN1;
               endcase
            end
         end
         S_REP: begin
            cmd.do_report = 1'b1;
            state_in      = S_IDLE;
         end
         S_ACK: begin
            if (!st.ack_hit) begin
               state_in = S_IDLE;
            end else if (st.out_free) begin
               cmd.do_ack = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN1: begin
            cmd.scan1_step = 1'b1;
            cmd.idx_inc    = 1'b1;
            if (st.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_LEAD;
            end
         end
         S_LEAD: begin
            if (!st.lead_diff) begin
               state_in = S_SCAN2;
            end else if (st.out_free) begin
               cmd.lead_step = 1'b1;
               state_in      = S_SCAN2;
            end
         end
         S_SCAN2: begin
            if (!st.scan2_emit || st.out_free) begin
               cmd.scan2_step = 1'b1;
               cmd.idx_inc    = 1'b1;
               if (st.idx_last) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.done_step = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_rep_short: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REP |=> state_ff == S_IDLE)
      else $error("report not finished in one cycle");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == S_IDLE)
      else $error("item taken while busy");
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN1 && st.idx_last) |=> state_ff == S_LEAD)
      else $error("first scan did not hand over to election");
endmodule
`default_nettype wire

>>> sv/nler_datapath.sv
// Datapath for the node liveness block: node table, election, command retry,
// configuration registers and the result register. Uses nler_pkg.
`default_nettype none
module nler_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic [1:0]         in_op,
   input  wire logic [nler_pkg::ID_W-1:0] in_id,
   input  wire logic [7:0]         in_batt,
   input  wire logic [31:0]        in_aseq,
   input  wire logic [31:0]        in_now,
   input  wire nler_pkg::cmd_type  cmd,
   output nler_pkg::stat_type      st,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_kind,
   output logic [nler_pkg::ID_W-1:0] rsp_node,
   output logic [1:0]              rsp_role,
   output logic [31:0]             rsp_seq,
   output logic [2:0]              rsp_retry,
   output logic                    rsp_last
);
   import nler_pkg::*;

   // configuration
   logic [15:0] silence_ff, timeout_ff;
   logic [2:0]  rlimit_ff;

   // latched item
   logic [1:0]      op_ff;
   logic [ID_W-1:0] id_ff;
   logic [7:0]      batt_ff;
   logic [31:0]     aseq_ff, now_ff;

   // node table
   logic            present_ff [NODE_SLOTS];
   logic [1:0]      status_ff  [NODE_SLOTS];
   logic [7:0]      nbatt_ff   [NODE_SLOTS];
   logic [31:0]     seen_ff    [NODE_SLOTS];
   logic [1:0]      acked_ff   [NODE_SLOTS];
   logic            pvld_ff    [NODE_SLOTS];
   logic [1:0]      prole_ff   [NODE_SLOTS];
   logic [31:0]     pseq_ff    [NODE_SLOTS];
   logic [2:0]      pretry_ff  [NODE_SLOTS];
   logic [31:0]     psent_ff   [NODE_SLOTS];

   logic [31:0]     nseq_ff, nseq_in;
   logic [ID_W-1:0] prev_ff, prev_in;
   logic [ID_W-1:0] leader_ff, leader_in;
   logic [7:0]      best_ff, best_in;
   logic            bvld_ff, bvld_in;
   logic [ID_W-1:0] idx_ff, idx_in;

   // result register
   logic            ov_ff, ov_in;
   logic [2:0]      ok_ff, ok_in;
   logic [ID_W-1:0] on_ff, on_in;
   logic [1:0]      or_ff, or_in;
   logic [31:0]     os_ff, os_in;
   logic [2:0]      ot_ff, ot_in;
   logic            ol_ff, ol_in;

   logic        out_free;
   logic        cur_present, cur_online_eff, cur_silent, elect;
   logic        cur_online, pend_keep, need_send, timed_out, give_up;
   logic [1:0]  cur_role;
   logic [31:0] seen_age, sent_age;
   logic [2:0]  retry_inc;
   logic        ack_hit;

   assign out_free = !ov_ff || rsp_ready;

   // first scan: silence check and election for the indexed entry
   always_comb begin
      cur_present    = present_ff[idx_ff];
      seen_age       = now_ff - seen_ff[idx_ff];
      cur_silent     = cur_present && status_ff[idx_ff] != ST_FAULT &&
                       seen_age > {16'd0, silence_ff};
      cur_online_eff = cur_present && !cur_silent && status_ff[idx_ff] == ST_ONLINE;
      elect          = cur_online_eff && (!bvld_ff || nbatt_ff[idx_ff] > best_ff);
   end

   // second scan: role command decision for the indexed entry
   always_comb begin
      cur_online = cur_present && status_ff[idx_ff] == ST_ONLINE;
      cur_role   = (idx_ff == leader_ff) ? ROLE_LEADER : ROLE_FOLLOWER;
      pend_keep  = pvld_ff[idx_ff] && prole_ff[idx_ff] == cur_role;
      need_send  = !pend_keep && acked_ff[idx_ff] != cur_role;
      sent_age   = now_ff - psent_ff[idx_ff];
      timed_out  = pend_keep && sent_age >= {16'd0, timeout_ff};
      give_up    = timed_out && pretry_ff[idx_ff] >= rlimit_ff;
      retry_inc  = pretry_ff[idx_ff] + 3'd1;
   end

   assign ack_hit = id_ff != '0 && cur_present && pvld_ff[idx_ff] &&
                    pseq_ff[idx_ff] == aseq_ff;

   assign st.op         = in_op;
   assign st.out_free   = out_free;
   assign st.ack_hit    = ack_hit;
   assign st.lead_diff  = leader_ff != prev_ff;
   assign st.scan2_emit = cur_online && (need_send || timed_out);
   assign st.idx_last   = idx_ff == ID_W'(NODE_SLOTS - 1);

   // scalar next values and result register
   always_comb begin
      nseq_in   = nseq_ff;
      prev_in   = prev_ff;
      leader_in = leader_ff;
      best_in   = best_ff;
      bvld_in   = bvld_ff;
      idx_in    = idx_ff;
      ov_in     = ov_ff && !rsp_ready;
      ok_in     = ok_ff;
      on_in     = on_ff;
      or_in     = or_ff;
      os_in     = os_ff;
      ot_in     = ot_ff;
      ol_in     = ol_ff;
      if (cmd.load_item) begin
         idx_in    = (in_op == OP_PASS) ? '0 : in_id;
         leader_in = '0;
         bvld_in   = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.scan1_step && elect) begin
         best_in   = nbatt_ff[idx_ff];
         bvld_in   = 1'b1;
         leader_in = idx_ff;
      end
      if (cmd.do_ack) begin
         ov_in = 1'b1; ok_in = EV_ACK; on_in = id_ff; or_in = prole_ff[idx_ff];
         os_in = aseq_ff; ot_in = '0; ol_in = 1'b1;
      end
      if (cmd.lead_step) begin
         prev_in = leader_ff;
         ov_in = 1'b1; ok_in = EV_LEADER; on_in = leader_ff; or_in = ROLE_IDLE;
         os_in = '0; ot_in = '0; ol_in = 1'b0;
      end
      if (cmd.scan2_step && cur_online) begin
         if (need_send) begin
            nseq_in = nseq_ff + 32'd1;
            ov_in = 1'b1; ok_in = EV_SEND; on_in = idx_ff; or_in = cur_role;
            os_in = nseq_ff; ot_in = '0; ol_in = 1'b0;
         end else if (give_up) begin
            ov_in = 1'b1; ok_in = EV_TIMEOUT; on_in = idx_ff; or_in = prole_ff[idx_ff];
            os_in = pseq_ff[idx_ff]; ot_in = pretry_ff[idx_ff]; ol_in = 1'b0;
         end else if (timed_out) begin
            ov_in = 1'b1; ok_in = EV_RETRY; on_in = idx_ff; or_in = prole_ff[idx_ff];
            os_in = pseq_ff[idx_ff]; ot_in = retry_inc; ol_in = 1'b0;
         end
      end
      if (cmd.done_step) begin
         ov_in = 1'b1; ok_in = EV_DONE; on_in = '0; or_in = ROLE_IDLE;
         os_in = '0; ot_in = '0; ol_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= 16'd2500;
         timeout_ff <= 16'd600;
         rlimit_ff  <= 3'd5;
         nseq_ff    <= 32'd1;
         prev_ff    <= '0;
         ov_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SILENCE: silence_ff <= csr_wdata;
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               CSR_RETRY:   rlimit_ff  <= csr_wdata[2:0];
               default:     ;
            endcase
         end
         nseq_ff <= nseq_in;
         prev_ff <= prev_in;
         ov_ff   <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      leader_ff <= leader_in;
      best_ff   <= best_in;
      bvld_ff   <= bvld_in;
      idx_ff    <= idx_in;
      ok_ff     <= ok_in;
      on_ff     <= on_in;
      or_ff     <= or_in;
      os_ff     <= os_in;
      ot_ff     <= ot_in;
      ol_ff     <= ol_in;
      if (cmd.load_item) begin
         op_ff   <= in_op;
         id_ff   <= in_id;
         batt_ff <= in_batt;
         aseq_ff <= in_aseq;
         now_ff  <= in_now;
      end
   end

   // table state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODE_SLOTS; i++) begin
            present_ff[i] <= 1'b0;
            status_ff[i]  <= ST_ONLINE;
            nbatt_ff[i]   <= '0;
            acked_ff[i]   <= ROLE_IDLE;
            pvld_ff[i]    <= 1'b0;
         end
      end else begin
         if (cmd.do_report && id_ff != '0) begin
            if (!present_ff[idx_ff]) begin
               present_ff[idx_ff] <= 1'b1;
               acked_ff[idx_ff]   <= ROLE_IDLE;
               pvld_ff[idx_ff]    <= 1'b0;
            end
            status_ff[idx_ff] <= (op_ff == OP_STATUS) ? ST_ONLINE : ST_FAULT;
            nbatt_ff[idx_ff]  <= (op_ff == OP_STATUS) ? batt_ff : 8'd0;
         end
         if (cmd.do_ack) begin
            acked_ff[idx_ff] <= prole_ff[idx_ff];
            pvld_ff[idx_ff]  <= 1'b0;
         end
         if (cmd.scan1_step && cur_silent) begin
            status_ff[idx_ff] <= ST_OFFLINE;
         end
         if (cmd.scan2_step && cur_online) begin
            if (need_send) begin
               pvld_ff[idx_ff] <= 1'b1;
            end else if (!pend_keep || give_up) begin
               pvld_ff[idx_ff] <= 1'b0;
            end
         end
      end
   end

   // table state written before it is read
   always_ff @(posedge clock) begin
      if (cmd.do_report && id_ff != '0) begin
         seen_ff[idx_ff] <= now_ff;
      end
      if (cmd.scan2_step && cur_online) begin
         if (need_send) begin
            prole_ff[idx_ff]  <= cur_role;
            pseq_ff[idx_ff]   <= nseq_ff;
            pretry_ff[idx_ff] <= '0;
            psent_ff[idx_ff]  <= now_ff;
         end else if (timed_out && !give_up) begin
            pretry_ff[idx_ff] <= retry_inc;
            psent_ff[idx_ff]  <= now_ff;
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind  = ok_ff;
   assign rsp_node  = on_ff;
   assign rsp_role  = or_ff;
   assign rsp_seq   = os_ff;
   assign rsp_retry = ot_ff;
   assign rsp_last  = ol_ff;

   a_no_slot0: assert property (@(posedge clock) disable iff (reset)
      !present_ff[0])
      else $error("reserved slot became present");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      cmd.done_step |=> ov_ff && ol_ff && ok_ff == EV_DONE)
      else $error("pass done not loaded as last result");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan2_step && cur_online && (need_send || timed_out)) |-> out_free)
      else $error("command result would overwrite a waiting result");
endmodule
`default_nettype wire

>>> sv/node_liveness_election_retry_top.sv
// Top level of the node liveness, leader election and role retry block.
// Joins nler_ctrl and nler_datapath; uses nler_pkg.
`default_nettype none
// One item is handled at a time. A status or fault report passes through the
// report state back to idle; an ack waits for the result register when it
// has a result to give. A service pass walks the sixteen-entry table twice,
// one entry per cycle through a single table port (silence check and
// election, then role commands), but the second walk holds on an entry whose
// command waits on a stalled consumer. The leader check comes between the
// walks and the closing result after them; both can wait on that consumer.
// Results leave through one output register, so the next item is taken while
// the last result of a run still waits.
module node_liveness_election_retry_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // node_id, battery_level, acked_seq, now_ms
   input  wire logic [1:0]  req_tuser,  // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // target_node, role_code, command_seq, retry_number
   output logic [2:0]       rsp_tuser,  // event_kind
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import nler_pkg::*;

   cmd_type         cmd;
   stat_type        st;
   logic            idle;
   logic            req_accept;
   logic [ID_W-1:0] rsp_node;
   logic [1:0]      rsp_role;
   logic [31:0]     rsp_seq;
   logic [2:0]      rsp_retry;

   assign req_tready = idle;
   assign req_accept = req_tvalid && idle;

   nler_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .idle       (idle),
      .st         (st),
      .cmd        (cmd)
   );

   nler_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_op     (req_tuser),
      .in_id     (req_tdata[3:0]),
      .in_batt   (req_tdata[11:4]),
      .in_aseq   (req_tdata[43:12]),
      .in_now    (req_tdata[75:44]),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_node  (rsp_node),
      .rsp_role  (rsp_role),
      .rsp_seq   (rsp_seq),
      .rsp_retry (rsp_retry),
      .rsp_last  (rsp_tlast)
   );

   // pack the result fields, zero fill to whole bytes
   assign rsp_tdata = {7'd0, rsp_retry, rsp_seq, rsp_role, rsp_node};
endmodule
`default_nettype wire
